// ===== rtl/pm4sc_pkg.sv =====
// shared types, constants and opcode decode for the pm4 packet census
`timescale 1ns / 1ps

package pm4sc_pkg;

    localparam int NUM_COUNTERS = 15;
    localparam int PL_W         = 15;

    typedef logic [3:0] cnt_idx_t;
    typedef logic [3:0] op_class_t;
    typedef logic [1:0] ptype_t;

    localparam logic CMD_DWORD = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam ptype_t PTYPE_0 = 2'd0;
    localparam ptype_t PTYPE_1 = 2'd1;
    localparam ptype_t PTYPE_2 = 2'd2;
    localparam ptype_t PTYPE_3 = 2'd3;

    localparam cnt_idx_t IDX_CLASS_BASE = 4'd3;
    localparam cnt_idx_t IDX_WINDOWS    = 4'd12;
    localparam cnt_idx_t IDX_DWORDS     = 4'd13;
    localparam cnt_idx_t IDX_MIDPKT     = 4'd14;
    localparam cnt_idx_t IDX_NONE       = 4'd15;

    localparam op_class_t CLASS_NOP        = 4'd0;
    localparam op_class_t CLASS_DRAW_INDX  = 4'd1;
    localparam op_class_t CLASS_DRAW_INDX2 = 4'd2;
    localparam op_class_t CLASS_IM_LOAD    = 4'd3;
    localparam op_class_t CLASS_SET_CONST  = 4'd4;
    localparam op_class_t CLASS_LOAD_ALU   = 4'd5;
    localparam op_class_t CLASS_MEM_WRITE  = 4'd6;
    localparam op_class_t CLASS_EVENT      = 4'd7;
    localparam op_class_t CLASS_OTHER      = 4'd8;
    localparam op_class_t CLASS_NONE       = 4'd9;

    localparam logic [7:0] OP_NOP         = 8'h10;
    localparam logic [7:0] OP_DRAW_INDX   = 8'h22;
    localparam logic [7:0] OP_DRAW_INDX2  = 8'h36;
    localparam logic [7:0] OP_IM_LOAD     = 8'h27;
    localparam logic [7:0] OP_IM_LOAD_IMM = 8'h2b;
    localparam logic [7:0] OP_SET_CONST   = 8'h2d;
    localparam logic [7:0] OP_LOAD_ALU    = 8'h2f;
    localparam logic [7:0] OP_MEM_WRITE   = 8'h3d;
    localparam logic [7:0] OP_EVENT_WRITE = 8'h46;
    localparam logic [7:0] OP_EVENT_LO    = 8'h58;
    localparam logic [7:0] OP_EVENT_HI    = 8'h5b;

    // per-transaction census events, already qualified by the stage advancing
    typedef struct packed {
        logic      dword;
        logic      header;
        ptype_t    ptype;
        op_class_t cls;
        logic      window_end;
        logic      mid;
    } census_evt_t;

    function automatic op_class_t opcode_class(input logic [7:0] op);
        op_class_t c;
        case (op)
            OP_NOP:                       c = CLASS_NOP;
            OP_DRAW_INDX:                 c = CLASS_DRAW_INDX;
            OP_DRAW_INDX2:                c = CLASS_DRAW_INDX2;
            OP_IM_LOAD, OP_IM_LOAD_IMM:   c = CLASS_IM_LOAD;
            OP_SET_CONST:                 c = CLASS_SET_CONST;
            OP_LOAD_ALU:                  c = CLASS_LOAD_ALU;
            OP_MEM_WRITE:                 c = CLASS_MEM_WRITE;
            default:
            begin
                if (op inside {OP_EVENT_WRITE, [OP_EVENT_LO:OP_EVENT_HI]})
                    c = CLASS_EVENT;
                else
                    c = CLASS_OTHER;
            end
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/pm4sc_stream_if.sv =====
// valid/ready stream interfaces for command and result transactions
`timescale 1ns / 1ps

interface pm4sc_cmd_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] word;
    logic        last_in_window;
    logic [3:0]  counter_index;

    modport source (output valid, cmd, word, last_in_window, counter_index, input ready);
    modport sink   (input valid, cmd, word, last_in_window, counter_index, output ready);
endinterface

interface pm4sc_rsp_if;
    logic        valid;
    logic        ready;
    logic        is_header;
    logic [1:0]  packet_type;
    logic [3:0]  opcode_class;
    logic        mid_packet;
    logic [31:0] counter_value;

    modport source (output valid, is_header, packet_type, opcode_class, mid_packet,
                    counter_value, input ready);
    modport sink   (input valid, is_header, packet_type, opcode_class, mid_packet,
                    counter_value, output ready);
endinterface

// ===== rtl/pm4sc_parse.sv =====
// packet boundary tracker: header decode and remaining payload count
`timescale 1ns / 1ps

module pm4sc_parse
    import pm4sc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  logic        cmd,
    input  logic [31:0] word,
    input  logic        last_in_window,
    output census_evt_t evt
);

    logic [PL_W-1:0] payload_left_reg;
    logic [PL_W-1:0] payload_left_next;
    logic [PL_W-1:0] pl_after;
    logic [PL_W-1:0] pkt_len;
    logic            at_header;
    logic            is_dword;
    ptype_t          ptype;

    assign is_dword  = fire && (cmd == CMD_DWORD);
    assign at_header = (payload_left_reg == '0);
    assign ptype     = word[31:30];
    assign pkt_len   = {1'b0, word[29:16]} + PL_W'(1);

    always_comb
    begin
        pl_after = payload_left_reg - PL_W'(1);
        if (at_header)
        begin
            case (ptype)
                PTYPE_0, PTYPE_3: pl_after = pkt_len;
                PTYPE_1:          pl_after = PL_W'(2);
                default:          pl_after = '0;
            endcase
        end
    end

    always_comb
    begin
        payload_left_next = payload_left_reg;
        if (is_dword)
            payload_left_next = last_in_window ? '0 : pl_after;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            payload_left_reg <= '0;
        else
            payload_left_reg <= payload_left_next;
    end

    always_comb
    begin
        evt.dword      = is_dword;
        evt.header     = is_dword && at_header;
        evt.ptype      = (is_dword && at_header) ? ptype : PTYPE_0;
        evt.cls        = (is_dword && at_header && ptype == PTYPE_3) ?
                         opcode_class(word[15:8]) : CLASS_NONE;
        evt.window_end = is_dword && last_in_window;
        evt.mid        = is_dword && last_in_window && (pl_after != '0);
    end

endmodule

// ===== rtl/pm4sc_census.sv =====
// bank of fifteen wrapping census counters with one read port
`timescale 1ns / 1ps

module pm4sc_census
    import pm4sc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  census_evt_t evt,
    input  cnt_idx_t    rd_idx,
    output logic [31:0] rd_value
);

    logic [COUNT_WIDTH-1:0] cnt_reg  [NUM_COUNTERS];
    logic [COUNT_WIDTH-1:0] cnt_next [NUM_COUNTERS];
    logic [NUM_COUNTERS-1:0] bump;
    logic [63:0]             rd_wide;

    always_comb
    begin
        bump = '0;
        if (evt.header)
        begin
            if (evt.ptype == PTYPE_3)
                bump[IDX_CLASS_BASE + evt.cls] = 1'b1;
            else
                bump[evt.ptype] = 1'b1;
        end
        bump[IDX_WINDOWS] = evt.window_end;
        bump[IDX_DWORDS]  = evt.dword;
        bump[IDX_MIDPKT]  = evt.mid;
    end

    always_comb
    begin
        for (int i = 0; i < NUM_COUNTERS; i++)
            cnt_next[i] = cnt_reg[i] + COUNT_WIDTH'(bump[i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COUNTERS; i++)
                cnt_reg[i] <= '0;
        end
        else
        begin
            for (int i = 0; i < NUM_COUNTERS; i++)
                cnt_reg[i] <= cnt_next[i];
        end
    end

    always_comb
    begin
        rd_wide = '0;
        if (rd_idx != IDX_NONE)
            rd_wide = 64'(cnt_reg[rd_idx]);
        rd_value = rd_wide[31:0];
    end

endmodule

// ===== rtl/pm4_packet_stream_census_top.sv =====
// top level of the pm4 packet stream census
//
//  channel  dir  payload                                                  transfer
//  req      in   cmd, word, last_in_window, counter_index                 valid & ready
//  rsp      out  is_header, packet_type, opcode_class, mid_packet,        valid & ready
//                counter_value
//
// one transaction per cycle while rsp is not stalled; rsp valid once the req has passed both registers
// stages: input register, then parse and counter update into the result register
// a read sees every command dword accepted before it
// rsp stall backs up through both registers to req.ready
// rst_n clears the parser to expect a header and all counters to zero
`timescale 1ns / 1ps

module pm4_packet_stream_census_top
    import pm4sc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    pm4sc_cmd_if.sink    req,
    pm4sc_rsp_if.source  rsp
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        s1_cmd_reg;
    logic [31:0] s1_word_reg;
    logic        s1_last_reg;
    cnt_idx_t    s1_idx_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_hdr_reg;
    ptype_t      out_ptype_reg;
    op_class_t   out_cls_reg;
    logic        out_mid_reg;
    logic [31:0] out_value_reg;

    logic        out_free;
    logic        fire;
    logic        req_take;
    census_evt_t evt;
    logic [31:0] rd_value;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign fire      = s1_valid_reg && out_free;
    assign req.ready = !s1_valid_reg || out_free;
    assign req_take  = req.valid && req.ready;

    assign s1_valid_next  = req_take ? 1'b1 : (fire ? 1'b0 : s1_valid_reg);
    assign out_valid_next = fire ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            s1_cmd_reg  <= req.cmd;
            s1_word_reg <= req.word;
            s1_last_reg <= req.last_in_window;
            s1_idx_reg  <= req.counter_index;
        end
    end

    pm4sc_parse u_parse (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .cmd            (s1_cmd_reg),
        .word           (s1_word_reg),
        .last_in_window (s1_last_reg),
        .evt            (evt)
    );

    pm4sc_census #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_census (
        .clk      (clk),
        .rst_n    (rst_n),
        .evt      (evt),
        .rd_idx   (s1_idx_reg),
        .rd_value (rd_value)
    );

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_hdr_reg   <= evt.header;
            out_ptype_reg <= evt.ptype;
            out_cls_reg   <= evt.cls;
            out_mid_reg   <= evt.mid;
            out_value_reg <= (s1_cmd_reg == CMD_READ) ? rd_value : 32'd0;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.is_header     = out_hdr_reg;
    assign rsp.packet_type   = out_ptype_reg;
    assign rsp.opcode_class  = out_cls_reg;
    assign rsp.mid_packet    = out_mid_reg;
    assign rsp.counter_value = out_value_reg;

`ifndef SYNTHESIS
    // a read transaction never reports header or window status
    a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
        fire && s1_cmd_reg == CMD_READ |=>
            !rsp.is_header && !rsp.mid_packet && rsp.opcode_class == CLASS_NONE)
        else $error("read transaction carried parse status");

    // an opcode class only accompanies a type-3 header
    a_class_type3: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.opcode_class != CLASS_NONE |->
            rsp.is_header && rsp.packet_type == PTYPE_3)
        else $error("opcode class without type-3 header");

    // a mid-packet flag is never paired with a counter value
    a_mid_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.mid_packet |-> rsp.counter_value == 32'd0)
        else $error("mid-packet flag on a read result");

    // the input stage only blocks while it holds a stalled transaction
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> s1_valid_reg && out_valid_reg && !rsp.ready)
        else $error("input blocked without a stall");
`endif

endmodule
